>>> rtl/rbbp_pkg.sv
package rbbp_pkg;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_TAKE    = 2'd2,
		MODE_PEEK    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_ALLOC = 2'd2,
		ST_SATURATED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC
	} state_t;

	localparam int WORD_BITS = 32;
	localparam logic [7:0] RC_ONE = 8'd1;
	localparam logic [7:0] RC_MAX = 8'd255;

	// highest set bit of a map word, split into byte select and bit select
	function automatic logic [4:0] msb32(input logic [31:0] v);
		logic [3:0] grp;
		logic [1:0] gsel;
		logic [7:0] byte_v;
		logic [2:0] lo;
		for (int k = 0; k < 4; k++) begin
			grp[k] = |v[k*8 +: 8];
		end
		if (grp[3]) begin
			gsel = 2'd3;
		end else if (grp[2]) begin
			gsel = 2'd2;
		end else if (grp[1]) begin
			gsel = 2'd1;
		end else begin
			gsel = 2'd0;
		end
		byte_v = v[gsel*8 +: 8];
		lo = 3'd0;
		for (int j = 0; j < 8; j++) begin
			if (byte_v[j]) begin
				lo = 3'(j);
			end
		end
		return {gsel, lo};
	endfunction

endpackage

>>> rtl/rbbp_req_if.sv
interface rbbp_req_if import rbbp_pkg::*; ();
	logic        valid;
	logic        ready;
	mode_t       mode;
	logic [6:0]  block_index;

	modport source (output valid, mode, block_index, input ready);
	modport sink (input valid, mode, block_index, output ready);
endinterface

>>> rtl/rbbp_res_if.sv
interface rbbp_res_if import rbbp_pkg::*; ();
	logic        valid;
	logic        ready;
	status_t     status;
	logic [6:0]  block_index_res;
	logic [7:0]  refs_left;
	logic [7:0]  used_count;
	logic [7:0]  max_used;

	modport source (output valid, status, block_index_res, refs_left, used_count, max_used,
		input ready);
	modport sink (input valid, status, block_index_res, refs_left, used_count, max_used,
		output ready);
endinterface

>>> rtl/rbbp_count_mem.sv
module rbbp_count_mem import rbbp_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// entries never written since clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : 8'd0;

endmodule

>>> rtl/refcounted_bitmap_block_pool_core.sv
// Block pool allocator with per-block reference counts. The free bitmap lives
// in a memory of 32-bit words and the counts in a second memory; each request
// reads them and, where it changes them, updates and writes them back.
// Release, take and peek pass through the execute state to the output
// register. Allocate examines bitmap words from the lowest-free-word hint
// upward, one word per cycle from the bitmap memory. An empty pool is
// reported once the scan passes the last word, also when the hint already
// lies past it. One request is in flight at a time; a finished result sits
// in an output register, so the next request is taken while it waits.
// Writing pool_size resets the pool to all free at once, with no clearing
// pass.
module refcounted_bitmap_block_pool_core import rbbp_pkg::*; #(
	parameter int MAX_BLOCKS = 128,
	parameter int MAP_WORDS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	rbbp_req_if.sink    req,
	rbbp_res_if.source  res
);

	localparam int MAP_BITS = MAP_WORDS * WORD_BITS;
	localparam int CAPACITY = (MAX_BLOCKS < MAP_BITS) ? MAX_BLOCKS : MAP_BITS;
	localparam int RW = $clog2(MAX_BLOCKS);
	localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int HW = $clog2(MAP_WORDS + 1);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (CW > 8) ? CW : 8;
	localparam int IW = (RW + 1 > 8) ? RW + 1 : 8;
	localparam int TW = ((SW > WW + 5) ? SW : WW + 5) + 1;
	localparam int POOL_RESET = (128 > CAPACITY) ? CAPACITY : 128;

	// free bits of a word as left by initialization for the given size
	function automatic logic [31:0] init_word(input logic [WW-1:0] w,
		input logic [SW-1:0] size);
		logic [TW-1:0] base;
		logic [31:0]   m;
		base = TW'({w, 5'd0});
		for (int j = 0; j < WORD_BITS; j++) begin
			m[j] = (base + TW'(j)) < TW'(size);
		end
		return m;
	endfunction

	state_t              state_q, state_d;
	mode_t               mode_q;
	logic [6:0]          blk_q;
	logic [HW-1:0]       word_q, word_d;
	logic [SW-1:0]       pool_q, used_q, used_d, peak_q, peak_d;
	logic [HW-1:0]       hint_q, hint_d;
	logic                load_req;

	// bitmap memory
	logic [31:0]         fmem [MAP_WORDS];
	logic [31:0]         frd_q;
	logic [WW-1:0]       fw_addr_q;
	logic [MAP_WORDS-1:0] fvalid_q;
	logic                f_rd_en, f_wr_en;
	logic [WW-1:0]       f_rd_addr;
	logic [31:0]         f_wr_data;
	logic [31:0]         fw_eff, fw_cleared;
	logic [4:0]          msb;
	logic [WW+4:0]       aidx;

	// count memory
	logic                r_rd_en, r_wr_en;
	logic [RW-1:0]       r_rd_addr, r_wr_addr;
	logic [7:0]          r_wr_data, r_rd_data;

	logic                emit, slot_ok, in_pool;
	status_t             e_status;
	logic [6:0]          e_blk;
	logic [7:0]          e_rc, cur;
	logic [HW-1:0]       word_inc;
	logic [SW-1:0]       used_inc;
	logic [SW-1:0]       cfg_size;

	logic                res_valid_q;
	status_t             res_status_q;
	logic [6:0]          res_blk_q;
	logic [7:0]          res_rc_q, res_used_q, res_max_q;

	assign cfg_size = (SW'(cfg_wr_data) > SW'(CAPACITY)) ? SW'(CAPACITY) : SW'(cfg_wr_data);

	assign fw_eff     = fvalid_q[fw_addr_q] ? frd_q : init_word(fw_addr_q, pool_q);
	assign msb        = msb32(fw_eff);
	assign fw_cleared = fw_eff & ~(32'd1 << msb);
	assign aidx       = {fw_addr_q, msb};
	assign in_pool    = IW'(blk_q) < IW'(CAPACITY);
	assign cur        = in_pool ? r_rd_data : 8'd0;
	assign word_inc   = word_q + 1'b1;
	assign used_inc   = used_q + 1'b1;
	assign slot_ok    = !res_valid_q || res.ready;
	assign req.ready  = (state_q == S_IDLE);

	rbbp_count_mem #(
		.DEPTH(MAX_BLOCKS),
		.AW(RW)
	) u_counts (
		.clk(clk),
		.arst_n(arst_n),
		.clear(cfg_wr_en),
		.rd_en(r_rd_en),
		.rd_addr(r_rd_addr),
		.rd_data(r_rd_data),
		.wr_en(r_wr_en),
		.wr_addr(r_wr_addr),
		.wr_data(r_wr_data)
	);

	always_comb begin
		state_d   = state_q;
		word_d    = word_q;
		hint_d    = hint_q;
		used_d    = used_q;
		peak_d    = peak_q;
		load_req  = 1'b0;
		f_rd_en   = 1'b0;
		f_rd_addr = WW'(req.block_index >> 5);
		f_wr_en   = 1'b0;
		f_wr_data = fw_cleared;
		r_rd_en   = 1'b0;
		r_rd_addr = RW'(req.block_index);
		r_wr_en   = 1'b0;
		r_wr_addr = RW'(blk_q);
		r_wr_data = RC_ONE;
		emit      = 1'b0;
		e_status  = ST_OK;
		e_blk     = blk_q;
		e_rc      = 8'd0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					load_req = 1'b1;
					if (req.mode == MODE_ALLOC) begin
						word_d  = hint_q;
						f_rd_en = hint_q < HW'(MAP_WORDS);
						f_rd_addr = WW'(hint_q);
						state_d = S_SCAN;
					end else begin
						f_rd_en = 1'b1;
						r_rd_en = 1'b1;
						state_d = S_EXEC;
					end
				end
			end
			S_SCAN: begin
				if (word_q >= HW'(MAP_WORDS)) begin
					e_status = ST_EMPTY;
					e_blk    = 7'd0;
					if (slot_ok) begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end
				end else if (fw_eff != 32'd0) begin
					e_blk = 7'(aidx);
					e_rc  = RC_ONE;
					if (slot_ok) begin
						emit      = 1'b1;
						f_wr_en   = 1'b1;
						r_wr_en   = 1'b1;
						r_wr_addr = RW'(aidx);
						hint_d    = (fw_cleared == 32'd0) ? word_inc : word_q;
						used_d    = used_inc;
						peak_d    = (used_inc > peak_q) ? used_inc : peak_q;
						state_d   = S_IDLE;
					end
				end else begin
					// word is full, move on to the next one
					word_d    = word_inc;
					f_rd_en   = word_inc < HW'(MAP_WORDS);
					f_rd_addr = WW'(word_inc);
				end
			end
			S_EXEC: begin
				f_wr_data = fw_eff | (32'd1 << blk_q[4:0]);
				case (mode_q)
					MODE_RELEASE: begin
						if (cur == 8'd0) begin
							e_status = ST_NOT_ALLOC;
						end else if (cur > RC_ONE) begin
							e_rc      = cur - 8'd1;
							r_wr_data = cur - 8'd1;
							r_wr_en   = slot_ok;
						end else begin
							// last reference gone: block returns to the map
							r_wr_data = 8'd0;
							r_wr_en   = slot_ok;
							f_wr_en   = slot_ok;
							if (slot_ok) begin
								hint_d = (HW'(fw_addr_q) < hint_q) ? HW'(fw_addr_q) : hint_q;
								used_d = used_q - 1'b1;
							end
						end
					end
					MODE_TAKE: begin
						if (cur == 8'd0) begin
							e_status = ST_NOT_ALLOC;
						end else if (cur == RC_MAX) begin
							e_status = ST_SATURATED;
							e_rc     = RC_MAX;
						end else begin
							e_rc      = cur + 8'd1;
							r_wr_data = cur + 8'd1;
							r_wr_en   = slot_ok;
						end
					end
					default: begin
						e_rc = cur;
					end
				endcase
				if (slot_ok) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pool_q   <= SW'(POOL_RESET);
			hint_q   <= '0;
			used_q   <= '0;
			peak_q   <= '0;
			fvalid_q <= '0;
			word_q   <= '0;
		end else begin
			state_q <= state_d;
			word_q  <= word_d;
			if (cfg_wr_en) begin
				pool_q   <= cfg_size;
				hint_q   <= '0;
				used_q   <= '0;
				peak_q   <= '0;
				fvalid_q <= '0;
			end else begin
				hint_q <= hint_d;
				used_q <= used_d;
				peak_q <= peak_d;
				if (f_wr_en) begin
					fvalid_q[fw_addr_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (f_wr_en) begin
			fmem[fw_addr_q] <= f_wr_data;
		end
		if (f_rd_en) begin
			frd_q     <= fmem[f_rd_addr];
			fw_addr_q <= f_rd_addr;
		end
		if (load_req) begin
			mode_q <= req.mode;
			blk_q  <= req.block_index;
		end
	end

	// output register parts the result from the next request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_status_q <= e_status;
			res_blk_q    <= e_blk;
			res_rc_q     <= e_rc;
			res_used_q   <= used_d[7:0];
			res_max_q    <= peak_d[7:0];
		end
	end

	assign res.valid           = res_valid_q;
	assign res.status          = res_status_q;
	assign res.block_index_res = res_blk_q;
	assign res.refs_left       = res_rc_q;
	assign res.used_count      = res_used_q;
	assign res.max_used        = res_max_q;

endmodule

>>> rtl/rbbp_checker.sv
module rbbp_checker import rbbp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input status_t    status,
	input logic [6:0] block_index_res,
	input logic [7:0] refs_left,
	input logic [7:0] used_count,
	input logic [7:0] max_used
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(status) && $stable(block_index_res)
			&& $stable(refs_left) && $stable(used_count) && $stable(max_used))
		else $error("result word changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_EMPTY |-> block_index_res == 7'd0 && refs_left == 8'd0)
		else $error("empty pool result carries a block");

	a_not_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_NOT_ALLOC |-> refs_left == 8'd0)
		else $error("unallocated block reports references");

	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_SATURATED |-> refs_left == RC_MAX)
		else $error("saturated take without full count");

endmodule

bind refcounted_bitmap_block_pool_core rbbp_checker u_rbbp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.status(res.status),
	.block_index_res(res.block_index_res),
	.refs_left(res.refs_left),
	.used_count(res.used_count),
	.max_used(res.max_used)
);
